[rtl/core/bmon_pkg.sv]
// Shared widths, reset values, register indexes and types of the battery level monitor.
`default_nettype none

package bmon_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned NUM_THRESH = 5;

  // Serial divider operand widths
  localparam int unsigned DIV_NUM_W = 20;
  localparam int unsigned DIV_DEN_W = 12;

  // Default burst length
  localparam int unsigned SAMPLES_PER_READING_DEF = 8;

  // Ratiometric scale and debounce limit
  localparam logic [DIV_NUM_W-1:0] VOLT_SCALE   = DIV_NUM_W'(250);
  localparam logic [2:0]           MISMATCH_MAX = 3'd3;

  // Published level after reset and voltage saturation
  localparam logic [LEVEL_W-1:0] PUB_LEVEL_RST = 3'd5;
  localparam logic [VOLT_W-1:0]  VOLT_SAT      = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH0  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH1  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH2  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH3  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH4  = 3'd5;

  // Configuration reset values
  localparam logic [VOLT_W-1:0] INTERVAL_RST = 16'd50;
  localparam logic [VOLT_W-1:0] THRESH0_RST  = 16'd340;
  localparam logic [VOLT_W-1:0] THRESH1_RST  = 16'd360;
  localparam logic [VOLT_W-1:0] THRESH2_RST  = 16'd370;
  localparam logic [VOLT_W-1:0] THRESH3_RST  = 16'd385;
  localparam logic [VOLT_W-1:0] THRESH4_RST  = 16'd400;

  // Level thresholds, entry i is the voltage above which the level is at least i+1
  typedef logic [NUM_THRESH-1:0][VOLT_W-1:0] thresh_arr_t;

endpackage

`default_nettype wire

[rtl/core/bmon_if.sv]
// Valid/ready channel interfaces for ticks, results and configuration writes.
`default_nettype none

interface bmon_in_if
  import bmon_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] battery_sample;
  logic [SAMPLE_W-1:0] reference_sample;

  modport source (output valid, output battery_sample, output reference_sample, input ready);
  modport sink   (input valid, input battery_sample, input reference_sample, output ready);
endinterface

interface bmon_out_if
  import bmon_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] battery_level;
  logic               reading_done;
  logic [VOLT_W-1:0]  measured_voltage;

  modport source (output valid, output battery_level, output reading_done,
                  output measured_voltage, input ready);
  modport sink   (input valid, input battery_level, input reading_done,
                  input measured_voltage, output ready);
endinterface

interface bmon_cfg_if
  import bmon_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/bmon_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module bmon_div
  import bmon_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] dividend,
  input  wire logic [DIV_DEN_W-1:0] divisor,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] dq_r;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W+1:0] diff;
  logic                 qbit;

  // Shift next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, dq_r[DIV_NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign qbit  = ~diff[DIV_DEN_W+1];

  // Load operands on start, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= divisor;
        dq_r   <= dividend;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        dq_r  <= {dq_r[DIV_NUM_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

`default_nettype wire

[rtl/core/bmon_level.sv]
// Threshold classifier and debounce of the published battery level.
`default_nettype none

module bmon_level
  import bmon_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              upd,
  input  wire logic [VOLT_W-1:0] voltage,
  input  wire thresh_arr_t       thresh,
  output logic [LEVEL_W-1:0]     level
);

  logic [LEVEL_W-1:0] level_r;
  logic [2:0]         mis_r;
  logic [LEVEL_W-1:0] cls;
  logic [2:0]         mis_inc;

  // Pick the highest threshold exceeded
  always_comb begin
    cls = '0;
    for (int i = 0; i < NUM_THRESH; i++) begin
      if (voltage > thresh[i]) cls = LEVEL_W'(i + 1);
    end
  end

  assign mis_inc = mis_r + 3'd1;

  // Count differing readings, publish after more than the limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= PUB_LEVEL_RST;
      mis_r   <= '0;
    end else if (upd) begin
      if (cls != level_r) begin
        if (mis_inc > MISMATCH_MAX) begin
          mis_r   <= '0;
          level_r <= cls;
        end else begin
          mis_r <= mis_inc;
        end
      end else begin
        mis_r <= '0;
      end
    end
  end

  assign level = level_r;

endmodule

`default_nettype wire

[rtl/core/battery_level_monitor_core.sv]
// Top level of the battery level monitor: phase sequencer, sums, config and result register.
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          battery_sample[11:0], reference_sample[11:0]
//  out_ch    out  valid/ready          battery_level[2:0], reading_done, measured_voltage[15:0]
//  cfg_ch    in   valid/ready (ready=1) addr[2:0], data[15:0]
//
// Idle and collect ticks are answered directly; the result is registered the cycle after acceptance.
// A finish tick runs two serial divisions by the burst length before its result is registered.
// An analyze tick runs one serial division and a level update; the division is skipped when
// the reference average is zero. Writes to unknown indexes drop.
// Every division goes through the shared divider at one quotient bit per cycle (20 bits).
// A new tick is taken once the previous result has been taken from out_ch.
// Reset (rst_n low at a clock edge) restores all but the result payload and divider data.
`default_nettype none

module battery_level_monitor_core
  import bmon_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmon_in_if.sink    in_ch,
  bmon_out_if.source out_ch,
  bmon_cfg_if.sink   cfg_ch
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam logic [CNT_W-1:0]     SAMPLE_LAST = CNT_W'(SAMPLES_PER_READING);
  localparam logic [DIV_DEN_W-1:0] SAMPLE_DEN  = DIV_DEN_W'(SAMPLES_PER_READING);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COLLECT,
    PH_FINISH,
    PH_ANALYZE
  } phase_t;

  typedef enum logic [2:0] {
    ST_READY,
    ST_AVG_BAT,
    ST_AVG_REF,
    ST_VOLT,
    ST_LEVEL,
    ST_PUB
  } state_t;

  // Configuration registers
  logic [VOLT_W-1:0] interval_r;
  thresh_arr_t       thresh_r;

  // Sequencer and measurement state
  state_t               st_r;
  phase_t               phase_r;
  logic [VOLT_W-1:0]    idle_cnt_r;
  logic [CNT_W-1:0]     sample_cnt_r;
  logic [SUM_W-1:0]     bat_sum_r;
  logic [SUM_W-1:0]     ref_sum_r;
  logic [SAMPLE_W-1:0]  bat_avg_r;
  logic [SAMPLE_W-1:0]  ref_avg_r;
  logic [VOLT_W-1:0]    volt_r;

  // Divider request
  logic                 div_start_r;
  logic [DIV_NUM_W-1:0] div_num_r;
  logic [DIV_DEN_W-1:0] div_den_r;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // Result register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_done_r;
  logic [VOLT_W-1:0]  out_volt_r;

  logic               in_fire;
  logic               lvl_upd;
  logic [LEVEL_W-1:0] level;
  logic [VOLT_W-1:0]  idle_cnt_inc;
  logic [CNT_W-1:0]   sample_cnt_inc;
  logic [VOLT_W-1:0]  volt_sat;

  assign in_ch.ready    = (st_r == ST_READY) && !out_valid_r;
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign lvl_upd        = (st_r == ST_LEVEL);
  assign idle_cnt_inc   = idle_cnt_r + 1'b1;
  assign sample_cnt_inc = sample_cnt_r + 1'b1;

  // Double the quotient, clamp at full scale
  assign volt_sat = (div_quo[DIV_NUM_W-1:VOLT_W-1] != '0) ? VOLT_SAT
                                                         : {div_quo[VOLT_W-2:0], 1'b0};

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= INTERVAL_RST;
      thresh_r[0] <= THRESH0_RST;
      thresh_r[1] <= THRESH1_RST;
      thresh_r[2] <= THRESH2_RST;
      thresh_r[3] <= THRESH3_RST;
      thresh_r[4] <= THRESH4_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_INTERVAL: interval_r  <= cfg_ch.data;
        REG_THRESH0:  thresh_r[0] <= cfg_ch.data;
        REG_THRESH1:  thresh_r[1] <= cfg_ch.data;
        REG_THRESH2:  thresh_r[2] <= cfg_ch.data;
        REG_THRESH3:  thresh_r[3] <= cfg_ch.data;
        REG_THRESH4:  thresh_r[4] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Phase sequencer, divider requests and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_READY;
      phase_r      <= PH_IDLE;
      idle_cnt_r   <= '0;
      sample_cnt_r <= '0;
      bat_sum_r    <= '0;
      ref_sum_r    <= '0;
      bat_avg_r    <= '0;
      ref_avg_r    <= '0;
      volt_r       <= '0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;

      case (st_r)
        ST_READY: begin
          if (in_fire) begin
            case (phase_r)
              PH_IDLE: begin
                sample_cnt_r <= '0;
                bat_sum_r    <= '0;
                ref_sum_r    <= '0;
                if (idle_cnt_inc > interval_r) begin
                  idle_cnt_r <= '0;
                  phase_r    <= PH_COLLECT;
                end else begin
                  idle_cnt_r <= idle_cnt_inc;
                end
                out_valid_r <= 1'b1;
                out_level_r <= level;
                out_done_r  <= 1'b0;
                out_volt_r  <= volt_r;
              end
              PH_COLLECT: begin
                bat_sum_r <= bat_sum_r + SUM_W'(in_ch.battery_sample);
                ref_sum_r <= ref_sum_r + SUM_W'(in_ch.reference_sample);
                if (sample_cnt_inc >= SAMPLE_LAST) begin
                  sample_cnt_r <= '0;
                  phase_r      <= PH_FINISH;
                end else begin
                  sample_cnt_r <= sample_cnt_inc;
                end
                out_valid_r <= 1'b1;
                out_level_r <= level;
                out_done_r  <= 1'b0;
                out_volt_r  <= volt_r;
              end
              PH_FINISH: begin
                div_num_r   <= DIV_NUM_W'(bat_sum_r);
                div_den_r   <= SAMPLE_DEN;
                div_start_r <= 1'b1;
                st_r        <= ST_AVG_BAT;
              end
              PH_ANALYZE: begin
                phase_r <= PH_IDLE;
                if (ref_avg_r == '0) begin
                  volt_r <= VOLT_SAT;
                  st_r   <= ST_LEVEL;
                end else begin
                  div_num_r   <= DIV_NUM_W'(bat_avg_r) * VOLT_SCALE;
                  div_den_r   <= ref_avg_r;
                  div_start_r <= 1'b1;
                  st_r        <= ST_VOLT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_AVG_BAT: begin
          if (div_done) begin
            bat_avg_r   <= div_quo[SAMPLE_W-1:0];
            div_num_r   <= DIV_NUM_W'(ref_sum_r);
            div_den_r   <= SAMPLE_DEN;
            div_start_r <= 1'b1;
            st_r        <= ST_AVG_REF;
          end
        end
        ST_AVG_REF: begin
          if (div_done) begin
            ref_avg_r   <= div_quo[SAMPLE_W-1:0];
            phase_r     <= PH_ANALYZE;
            out_valid_r <= 1'b1;
            out_level_r <= level;
            out_done_r  <= 1'b0;
            out_volt_r  <= volt_r;
            st_r        <= ST_READY;
          end
        end
        ST_VOLT: begin
          if (div_done) begin
            volt_r <= volt_sat;
            st_r   <= ST_LEVEL;
          end
        end
        ST_LEVEL: begin
          st_r <= ST_PUB;
        end
        ST_PUB: begin
          out_valid_r <= 1'b1;
          out_level_r <= level;
          out_done_r  <= 1'b1;
          out_volt_r  <= volt_r;
          st_r        <= ST_READY;
        end
        default: st_r <= ST_READY;
      endcase
    end
  end

  // Shared serial divider
  bmon_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_num_r),
    .divisor  (div_den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Level classifier and debounce
  bmon_level u_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (lvl_upd),
    .voltage (volt_r),
    .thresh  (thresh_r),
    .level   (level)
  );

  // Drive result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.battery_level    = out_level_r;
  assign out_ch.reading_done     = out_done_r;
  assign out_ch.measured_voltage = out_volt_r;

endmodule

`default_nettype wire

[verif/battery_level_monitor_checker.sv]
// Checker for the battery level monitor: watches the channels, predicts each result and compares.
`timescale 1ns / 100ps

module battery_level_monitor_checker
  import bmon_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_PER_READING_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bmon_in_if          in_mon,
  bmon_out_if         out_mon,
  bmon_cfg_if         cfg_mon,
  output int unsigned mismatch_total,
  output int unsigned readings_pending,
  output int unsigned results_checked,
  output int unsigned readings_classified,
  output int unsigned level_changes
);

  typedef enum logic [1:0] {
    TICK_IDLE,
    TICK_COLLECT,
    TICK_FINISH,
    TICK_ANALYZE
  } tick_phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               done;
    logic [VOLT_W-1:0]  volt;
  } reading_t;

  // Register copies
  logic [CFG_DATA_W-1:0] interval_ticks;
  thresh_arr_t           thresholds;

  // Predicted block state
  tick_phase_t          phase;
  logic [15:0]          idle_ticks;
  logic [6:0]           burst_count;
  logic [SUM_W-1:0]     bat_sum;
  logic [SUM_W-1:0]     ref_sum;
  logic [SAMPLE_W-1:0]  bat_avg;
  logic [SAMPLE_W-1:0]  ref_avg;
  logic [LEVEL_W-1:0]   shown_level;
  logic [2:0]           disagree_count;
  logic [VOLT_W-1:0]    volt_reg;

  reading_t expected_readings[$];

  int unsigned fail_cnt         = 0;
  int unsigned checked_cnt      = 0;
  int unsigned analyzed_cnt     = 0;
  int unsigned level_change_cnt = 0;

  // Voltage in centivolts from the averaged battery/reference ratio, saturated
  function automatic logic [VOLT_W-1:0] ratio_to_centivolts(input logic [SAMPLE_W-1:0] bat_s,
                                                            input logic [SAMPLE_W-1:0] ref_s);
    int unsigned quot;
    if (ref_s == '0) begin
      return VOLT_SAT;
    end
    quot = 2 * ((32'(VOLT_SCALE) * 32'(bat_s)) / 32'(ref_s));
    if (quot > 32'(VOLT_SAT)) begin
      return VOLT_SAT;
    end
    return VOLT_W'(quot);
  endfunction

  // Highest threshold exceeded wins, scanned from the top regardless of order
  function automatic logic [LEVEL_W-1:0] level_of(input logic [VOLT_W-1:0] volt);
    for (int k = NUM_THRESH; k > 0; k--) begin
      if (volt > thresholds[k-1]) begin
        return LEVEL_W'(k);
      end
    end
    return '0;
  endfunction

  // Advance the predicted state by one tick and return the result it produces
  function automatic reading_t take_tick(input logic [SAMPLE_W-1:0] bat_s,
                                         input logic [SAMPLE_W-1:0] ref_s);
    logic [LEVEL_W-1:0] lvl;
    logic               done;
    done = 1'b0;
    case (phase)
      TICK_IDLE: begin
        burst_count = '0;
        bat_sum     = '0;
        ref_sum     = '0;
        idle_ticks  = idle_ticks + 16'd1;
        if (idle_ticks > interval_ticks) begin
          idle_ticks = '0;
          phase      = TICK_COLLECT;
        end
      end
      TICK_COLLECT: begin
        bat_sum     = bat_sum + SUM_W'(bat_s);
        ref_sum     = ref_sum + SUM_W'(ref_s);
        burst_count = burst_count + 7'd1;
        if (burst_count >= SAMPLES) begin
          burst_count = '0;
          phase       = TICK_FINISH;
        end
      end
      TICK_FINISH: begin
        bat_avg = SAMPLE_W'(bat_sum / SAMPLES);
        ref_avg = SAMPLE_W'(ref_sum / SAMPLES);
        phase   = TICK_ANALYZE;
      end
      default: begin
        phase    = TICK_IDLE;
        volt_reg = ratio_to_centivolts(bat_avg, ref_avg);
        lvl      = level_of(volt_reg);
        // Publish a new level only after more than three disagreeing readings in a row
        if (lvl != shown_level) begin
          disagree_count = disagree_count + 3'd1;
          if (disagree_count > MISMATCH_MAX) begin
            disagree_count   = '0;
            shown_level      = lvl;
            level_change_cnt = level_change_cnt + 1;
          end
        end else begin
          disagree_count = '0;
        end
        done         = 1'b1;
        analyzed_cnt = analyzed_cnt + 1;
      end
    endcase
    return '{level: shown_level, done: done, volt: volt_reg};
  endfunction

  // Track register writes, compare results, queue predictions
  always @(posedge clk) begin : track_readings
    reading_t want;
    if (!rst_n) begin
      interval_ticks = INTERVAL_RST;
      thresholds     = {THRESH4_RST, THRESH3_RST, THRESH2_RST, THRESH1_RST, THRESH0_RST};
      phase          = TICK_IDLE;
      idle_ticks     = '0;
      burst_count    = '0;
      bat_sum        = '0;
      ref_sum        = '0;
      bat_avg        = '0;
      ref_avg        = '0;
      shown_level    = PUB_LEVEL_RST;
      disagree_count = '0;
      volt_reg       = '0;
      expected_readings.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.addr)
          REG_INTERVAL: interval_ticks = cfg_mon.data;
          REG_THRESH0:  thresholds[0]  = cfg_mon.data;
          REG_THRESH1:  thresholds[1]  = cfg_mon.data;
          REG_THRESH2:  thresholds[2]  = cfg_mon.data;
          REG_THRESH3:  thresholds[3]  = cfg_mon.data;
          REG_THRESH4:  thresholds[4]  = cfg_mon.data;
          default: ;
        endcase
      end

      // Compare the oldest prediction with the result transaction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_readings.size() == 0) begin
          $error("result with no tick outstanding: level %0d done %0d voltage %0d",
                 out_mon.battery_level, out_mon.reading_done, out_mon.measured_voltage);
          fail_cnt = fail_cnt + 1;
        end else begin
          want        = expected_readings.pop_front();
          checked_cnt = checked_cnt + 1;
          if (out_mon.battery_level !== want.level) begin
            $error("battery_level: expected %0d, got %0d", want.level, out_mon.battery_level);
            fail_cnt = fail_cnt + 1;
          end
          if (out_mon.reading_done !== want.done) begin
            $error("reading_done: expected %0d, got %0d", want.done, out_mon.reading_done);
            fail_cnt = fail_cnt + 1;
          end
          if (out_mon.measured_voltage !== want.volt) begin
            $error("measured_voltage: expected %0d, got %0d", want.volt,
                   out_mon.measured_voltage);
            fail_cnt = fail_cnt + 1;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        expected_readings.push_back(take_tick(in_mon.battery_sample, in_mon.reference_sample));
      end
    end

    readings_pending    <= expected_readings.size();
    mismatch_total      <= fail_cnt;
    results_checked     <= checked_cnt;
    readings_classified <= analyzed_cnt;
    level_changes       <= level_change_cnt;
  end

endmodule

[verif/battery_level_monitor_core_tb.sv]
// Testbench top for the battery level monitor: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module battery_level_monitor_core_tb;
  import bmon_pkg::*;

  localparam int unsigned SAMPLES     = SAMPLES_PER_READING_DEF;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned NUM_PLANS   = 9;

  // Indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [CFG_DATA_W-1:0] interval;
    thresh_arr_t           limits;
    int unsigned           ticks;
  } monitor_setting_t;

  logic clk = 1'b0;
  logic rst_n;

  bmon_in_if  in_ch();
  bmon_out_if out_ch();
  bmon_cfg_if cfg_ch();

  int unsigned mismatch_total;
  int unsigned readings_pending;
  int unsigned results_checked;
  int unsigned readings_classified;
  int unsigned level_changes;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned ticks_sent    = 0;

  monitor_setting_t plans[NUM_PLANS];
  thresh_arr_t      default_limits;

  battery_level_monitor_core #(
    .SAMPLES_PER_READING(SAMPLES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  battery_level_monitor_checker #(
    .SAMPLES(SAMPLES)
  ) i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_ch),
    .out_mon             (out_ch),
    .cfg_mon             (cfg_ch),
    .mismatch_total      (mismatch_total),
    .readings_pending    (readings_pending),
    .results_checked     (results_checked),
    .readings_classified (readings_classified),
    .level_changes       (level_changes)
  );

  always #6 clk = ~clk;

  // Drive output ready: long hold on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when no transaction moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write every register, then an index that must be dropped
  task automatic load_setting(input monitor_setting_t s);
    write_reg(REG_INTERVAL, s.interval);
    for (int k = 0; k < NUM_THRESH; k++) begin
      write_reg(REG_THRESH0 + CFG_ADDR_W'(k), s.limits[k]);
    end
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one tick after random idle cycles; hold valid until it is taken
  task automatic offer_tick(input logic [SAMPLE_W-1:0] bat_s, input logic [SAMPLE_W-1:0] ref_s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.battery_sample   <= bat_s;
    in_ch.reference_sample <= ref_s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (readings_pending != 0);
  endtask

  // Episodes of steady samples aimed near a threshold, repeated for whole readings
  task automatic run_readings(input monitor_setting_t s);
    int unsigned sent;
    int unsigned period;
    int unsigned span;
    int unsigned target;
    int unsigned bat_n;
    int unsigned ref_n;
    int unsigned bat_j;
    int unsigned k;
    sent   = 0;
    period = 32'(s.interval) + SAMPLES + 3;
    while (sent < s.ticks) begin
      case ($urandom_range(3))
        0: begin
          ref_n  = $urandom_range(4095, 600);
          target = $urandom_range(800);
          bat_n  = target * ref_n / 500;
        end
        3: begin
          // Tiny or zero reference: zero, or a large battery sample, drives the voltage to saturation
          ref_n = $urandom_range(20);
          bat_n = $urandom_range(4095);
        end
        default: begin
          ref_n  = $urandom_range(4095, 600);
          k      = $urandom_range(NUM_THRESH - 1);
          target = 32'(s.limits[k]) + $urandom_range(24);
          target = (target > 12) ? target - 12 : 0;
          bat_n  = target * ref_n / 500;
        end
      endcase
      if (bat_n > 4095) begin
        bat_n = 4095;
      end
      span = $urandom_range(6, 1) * period;
      for (int t = 0; t < span && sent < s.ticks; t++) begin
        if ($urandom_range(99) < 8) begin
          offer_tick(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end else begin
          bat_j = bat_n + $urandom_range(3);
          if (bat_j > 4095) begin
            bat_j = 4095;
          end
          offer_tick(SAMPLE_W'(bat_j), SAMPLE_W'(ref_n));
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.battery_sample   = '0;
    in_ch.reference_sample = '0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.addr            = '0;
    cfg_ch.data            = '0;

    default_limits = {THRESH4_RST, THRESH3_RST, THRESH2_RST, THRESH1_RST, THRESH0_RST};
    plans[0] = '{interval: 16'd0,     limits: default_limits, ticks: 130};
    plans[1] = '{interval: 16'd2,     limits: default_limits, ticks: 130};
    plans[2] = '{interval: 16'd1,     limits: '0,             ticks: 90};
    plans[3] = '{interval: 16'd3,     limits: '1,             ticks: 90};
    plans[4] = '{interval: 16'd0,     limits: default_limits, ticks: 130};
    plans[5] = '{interval: 16'hFFFF,  limits: default_limits, ticks: 30};
    plans[6] = '{interval: 16'd0,     limits: default_limits, ticks: 130};
    plans[7] = '{interval: 16'd1,     limits: default_limits, ticks: 100};
    plans[8] = '{interval: INTERVAL_RST, limits: default_limits, ticks: 130};
    // Unordered thresholds around the working range, a tight cluster, and anywhere at all
    for (int k = 0; k < NUM_THRESH; k++) begin
      plans[4].limits[k] = CFG_DATA_W'($urandom_range(460, 300));
      plans[6].limits[k] = CFG_DATA_W'(360 + k);
      plans[7].limits[k] = CFG_DATA_W'($urandom);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero reference, then saturation, with extreme samples on ignored ticks
    load_setting('{interval: 16'd0, limits: default_limits, ticks: 0});
    for (int r = 0; r < 2; r++) begin
      offer_tick(12'hFFF, 12'hFFF);
      repeat (SAMPLES) offer_tick(12'hFFF, (r == 0) ? 12'h000 : 12'h001);
      offer_tick(12'h000, 12'h000);
      offer_tick(12'h000, 12'hFFF);
    end
    wait_for_results();

    // Random phases: receiver-heavy idling, then sender-heavy, then none
    for (int p = 0; p < NUM_PLANS; p++) begin
      send_idle_pct <= (p < 3) ? 29 : (p < 6) ? 76 : 0;
      recv_idle_pct <= (p < 3) ? 76 : (p < 6) ? 29 : 0;
      load_setting(plans[p]);
      if (p == 1 || p == 7) begin
        hold_requests <= hold_requests + 1;
      end
      run_readings(plans[p]);
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings, with both idling mixes and long stalls",
             ticks_sent, NUM_PLANS + 1);
    $display("Checked %0d results: %0d readings classified, published level changed %0d times",
             results_checked, readings_classified, level_changes);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
